>>> design/ffc_pkg.sv
// Package for float_floor_ceil_unit: formats, constants and shared types.
// No dependencies.
package ffc_pkg;

   localparam int unsigned DataWidth = 64;
   localparam int unsigned ShiftWidth = 6;

   localparam logic [63:0] SpOneBits = 64'h0000_0000_3F80_0000;
   localparam logic [63:0] DpOneBits = 64'h3FF0_0000_0000_0000;

   typedef enum logic {
      KIND_FLOOR = 1'b0,
      KIND_CEIL  = 1'b1
   } kind_type;

   // Operand word as it sits in the input register.
   typedef struct packed {
      logic     double_precision;
      kind_type kind;
      logic [DataWidth-1:0] value_bits;
   } operand_type;

endpackage

>>> design/ffc_round.sv
// Combinational floor/ceil of one binary32 or binary64 bit pattern.
// Depends on ffc_pkg.
module ffc_round
   import ffc_pkg::*;
(
   input  operand_type          operand,
   output logic [DataWidth-1:0] result_bits
);

   logic                 dbl;
   logic [DataWidth-1:0] bits;
   logic                 negative;
   logic [DataWidth-1:0] mag_mask;
   logic                 mag_zero;
   logic [10:0]          biased;
   logic [10:0]          bias;
   logic [5:0]           frac_w;
   logic                 exp_neg;
   logic [11:0]          drop;
   logic                 no_drop;
   logic [DataWidth-1:0] unit;
   logic [DataWidth-1:0] keep_mask;
   logic [DataWidth-1:0] truncated;
   logic                 bump;
   logic [DataWidth-1:0] one_bits;
   logic [DataWidth-1:0] sign_bit;
   logic                 is_ceil;

   always_comb begin
      dbl      = operand.double_precision;
      is_ceil  = (operand.kind == KIND_CEIL);
      bits     = dbl ? operand.value_bits : {32'd0, operand.value_bits[31:0]};
      negative = dbl ? bits[63] : bits[31];
      mag_mask = dbl ? 64'h7FFF_FFFF_FFFF_FFFF : 64'h0000_0000_7FFF_FFFF;
      sign_bit = dbl ? 64'h8000_0000_0000_0000 : 64'h0000_0000_8000_0000;
      one_bits = dbl ? DpOneBits : SpOneBits;
      mag_zero = ((bits & mag_mask) == '0);
      biased   = dbl ? bits[62:52] : {3'd0, bits[30:23]};
      bias     = dbl ? 11'd1023 : 11'd127;
      frac_w   = dbl ? 6'd52 : 6'd23;
      exp_neg  = (biased < bias);
      // drop = frac_w - (biased - bias), valid when exponent is not negative
      drop     = {6'd0, frac_w} + {1'b0, bias} - {1'b0, biased};
      no_drop  = drop[11] || (drop == 12'd0);
      unit      = 64'd1 << drop[ShiftWidth-1:0];
      keep_mask = ~(unit - 64'd1);
      truncated = bits & keep_mask;
      bump      = (truncated != bits) && (negative != is_ceil);

      if (exp_neg) begin
         if (mag_zero) begin
            result_bits = '0;
         end else if (!is_ceil) begin
            result_bits = negative ? (one_bits | sign_bit) : '0;
         end else begin
            result_bits = negative ? '0 : one_bits;
         end
      end else if (no_drop) begin
         result_bits = bits;
      end else begin
         result_bits = bump ? truncated + unit : truncated;
      end
   end

endmodule

>>> design/float_floor_ceil_unit.sv
// Top level of the floor/ceil unit: stream handshake, operand and result registers.
// Depends on ffc_pkg and ffc_round.
//
// Rounds one IEEE 754 binary32 (low 32 bits) or binary64 operand toward minus
// infinity (floor, tuser bit 0 = 0) or plus infinity (ceil, tuser bit 0 = 1).
// tuser bit 1 selects binary64. One word is accepted every cycle while the
// result side is not stalled. An accepted word is registered in the operand
// register, passes the combinational rounding logic and is registered in the
// result register, which drives rsp_tvalid and rsp_tdata.
// Magnitudes below one give +0.0 or +/-1.0 (signed zeros are not kept);
// integral values, infinities and NaNs pass through. Binary32 results have the
// upper 32 bits zero. Both stages advance whenever the result register is
// empty or being taken; the operand stage also fills whenever it is empty.
module float_floor_ceil_unit
   import ffc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [DataWidth-1:0] req_tdata,   // [63:0] value_bits
   input  logic [1:0]           req_tuser,   // [0] kind, [1] double_precision
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [DataWidth-1:0] rsp_tdata    // [63:0] result_bits
);

   operand_type          op_ff, op_in;
   logic                 op_valid_ff, op_valid_in;
   logic [DataWidth-1:0] res_ff, res_in;
   logic                 res_valid_ff, res_valid_in;
   logic [DataWidth-1:0] rounded;
   logic                 res_load, op_load;

   ffc_round u_round (
      .operand     (op_ff),
      .result_bits (rounded)
   );

   always_comb begin
      res_load     = !res_valid_ff || rsp_tready;
      op_load      = !op_valid_ff || res_load;
      req_tready   = op_load;
      op_in        = op_ff;
      op_valid_in  = op_valid_ff;
      res_in       = res_ff;
      res_valid_in = res_valid_ff;
      if (res_load) begin
         res_in       = rounded;
         res_valid_in = op_valid_ff;
      end
      if (op_load) begin
         op_in.value_bits       = req_tdata;
         op_in.kind             = kind_type'(req_tuser[0]);
         op_in.double_precision = req_tuser[1];
         op_valid_in            = req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      res_ff <= res_in;
      if (reset) begin
         op_valid_ff  <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         op_valid_ff  <= op_valid_in;
         res_valid_ff <= res_valid_in;
      end
   end

   assign rsp_tvalid = res_valid_ff;
   assign rsp_tdata  = res_ff;

   // binary32 results never carry upper bits
   assert property (@(posedge clock) disable iff (reset)
      (op_valid_ff && !op_ff.double_precision) |-> (rounded[63:32] == 32'd0))
      else $error("binary32 result has upper bits set");

   // a stalled result keeps its data
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("result changed while stalled");

   // a filled operand moves on whenever the result stage frees up
   assert property (@(posedge clock) disable iff (reset)
      (op_valid_ff && res_load) |=> rsp_tvalid)
      else $error("operand lost between stages");

endmodule

>>> tb/sv/float_floor_ceil_unit_test.sv
// Testbench for float_floor_ceil_unit: drives floor/ceil operands with random gaps
// and stalls, predicts each rounded pattern and checks results in order.
// Depends on ffc_pkg and the float_floor_ceil_unit RTL.
module float_floor_ceil_unit_test
   import ffc_pkg::*;
;

   // Rounding predictor for one format; frac_w is 23 or 52.
   function automatic logic [63:0] round_to_integral(logic [63:0] bits, logic up,
                                                     int frac_w, int exp_w,
                                                     logic [63:0] one_bits);
      int sign_pos;
      logic neg;
      logic [63:0] mag, mask, trunc;
      int unsigned exp_raw;
      int expo, drop;
      sign_pos = frac_w + exp_w;
      neg = bits[sign_pos];
      mag = bits & ((64'd1 << sign_pos) - 64'd1);
      exp_raw = 32'((bits >> frac_w) & ((64'd1 << exp_w) - 64'd1));
      expo = int'(exp_raw) - ((1 << (exp_w - 1)) - 1);
      if (expo < 0) begin
         if (mag == 64'd0) return 64'd0;
         if (!up) return neg ? (one_bits | (64'd1 << sign_pos)) : 64'd0;
         return neg ? 64'd0 : one_bits;
      end
      drop = frac_w - expo;
      if (drop <= 0) return bits;
      mask = ~((64'd1 << drop) - 64'd1);
      trunc = bits & mask;
      if (trunc != bits && (neg != up)) trunc = trunc + (64'd1 << drop);
      return trunc;
   endfunction

   class rounding_scoreboard;
      logic [63:0] expected_q[$];
      int mismatches;

      function void note_operand(logic [63:0] value, kind_type k, logic dbl);
         logic up;
         up = (k == KIND_CEIL);
         if (dbl) expected_q.push_back(round_to_integral(value, up, 52, 11, DpOneBits));
         else expected_q.push_back(
               round_to_integral({32'd0, value[31:0]}, up, 23, 8, SpOneBits) & 64'hFFFF_FFFF);
      endfunction

      function void check_result(logic [63:0] got);
         logic [63:0] want;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %h", got);
            return;
         end
         want = expected_q.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("result_bits expected %h got %h", want, got);
         end
      endfunction
   endclass

   logic clock, reset;
   logic req_tvalid, req_tready, rsp_tvalid, rsp_tready;
   logic [63:0] req_tdata, rsp_tdata;
   logic [1:0] req_tuser;
   logic sending_done;
   rounding_scoreboard board;

   float_floor_ceil_unit u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Mostly no gap at all, often a short one, now and then a long one.
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Offer one word and hold it until taken; gap cycles come first.
   task automatic send_word(logic [63:0] value, kind_type k, logic dbl);
      int gap;
      gap = gap_length();
      repeat (gap) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= {dbl, k};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_operand(value, k, dbl);
   endtask

   // Random operand aimed at interesting exponents around the binary point.
   function automatic logic [63:0] random_operand(logic dbl);
      logic [63:0] v;
      int r;
      v = {$urandom, $urandom};
      r = $urandom_range(0, 9);
      if (dbl) begin
         if (r < 6) v[62:52] = 11'(1023 + $urandom_range(0, 60) - 6);
         else if (r == 6) v[62:52] = 11'h7FF;
         else if (r == 7) v[62:52] = 11'd0;
         if ($urandom_range(0, 3) == 0) v[51:0] = v[51:0] & ~(52'd0 - 52'd1 >> $urandom_range(0, 52));
      end else begin
         if (r < 6) v[30:23] = 8'(127 + $urandom_range(0, 30) - 4);
         else if (r == 6) v[30:23] = 8'hFF;
         else if (r == 7) v[30:23] = 8'd0;
         if ($urandom_range(0, 3) == 0) v[22:0] = v[22:0] & ~(23'h7FFFFF >> $urandom_range(0, 23));
      end
      return v;
   endfunction

   // Directed operands: zeros, subnormals, fractions, carries, integral, inf, NaN.
   logic [63:0] sp_cases[10] = '{64'h0, 64'h8000_0000, 64'h0000_0001, 64'h8000_0001,
                                 64'h3F00_0000, 64'hBF7F_FFFF, 64'h3FFF_FFFF,
                                 64'hFFFF_FFFF_4B7F_FFFF, 64'h7F80_0000, 64'hFFC0_0001};
   logic [63:0] dp_cases[8] = '{64'h0, 64'h8000_0000_0000_0000, 64'h3FE0_0000_0000_0001,
                                64'hBFFF_FFFF_FFFF_FFFF, 64'h4330_0000_0000_0001,
                                64'h432F_FFFF_FFFF_FFFF, 64'hFFF0_0000_0000_0000,
                                64'hFFFF_FFFF_FFFF_FFFF};

   initial begin
      kind_type k;
      board = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      sending_done = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (sp_cases[i]) send_word(sp_cases[i], kind_type'(i % 2), 1'b0);
      foreach (dp_cases[i]) send_word(dp_cases[i], kind_type'((i + 1) % 2), 1'b1);
      for (int n = 0; n < 2000; n++) begin
         logic dbl;
         if (n == 1000) begin
            // drain fully before carrying on
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (board.expected_q.size() != 0) @(posedge clock);
         end
         dbl = 1'($urandom_range(0, 1));
         k = kind_type'($urandom_range(0, 1));
         send_word(random_operand(dbl), k, dbl);
      end
      req_tvalid <= 1'b0;
      sending_done <= 1'b1;
   end

   // Result side: random stalls, compare at each accepted word.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) board.check_result(rsp_tdata);
         rsp_tready <= (gap_length() == 0) || ($urandom_range(0, 2) == 0);
      end
   end

   initial begin
      @(posedge clock);
      wait (sending_done);
      while (board.expected_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (board.mismatches == 0 && board.expected_q.size() == 0)
         $display("float_floor_ceil_unit: match");
      else
         $display("float_floor_ceil_unit: mismatch");
      $finish;
   end

   initial begin
      #3000000;
      $display("float_floor_ceil_unit: mismatch");
      $finish;
   end
endmodule
